[sv/rtcodt_pkg.sv]
// ----------------------------------------------------------------------------
// rtcodt_pkg
// Shared types, codes and constants of the one-shot delay timer.
// ----------------------------------------------------------------------------
package rtcodt_pkg;

  // Default counter width
  localparam int COUNTER_BITS_DEF = 24;

  // Fixed field widths
  localparam int CMD_W       = 2;
  localparam int DELAY_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 24;
  localparam int MIN_TICKS_W = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [MIN_TICKS_W-1:0] MIN_TICKS_RST = 8'd3;

  // Tick rate and microseconds per second
  localparam longint unsigned TICK_HZ  = 64'd32768;
  localparam longint unsigned US_PER_S = 64'd1000000;

  // ticks = floor(us * 512 / 15625) = (us * RECIP_M) >> RECIP_SHIFT, exact for 32-bit us
  localparam int RECIP_W     = 42;
  localparam int RECIP_LO_W  = 21;
  localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
  localparam int RECIP_SHIFT = 46;
  localparam int QUOT_W      = 28;
  localparam logic [RECIP_W-1:0]    RECIP_M    = 42'd2305843009214;
  localparam logic [RECIP_LO_W-1:0] RECIP_M_LO = RECIP_M[RECIP_LO_W-1:0];
  localparam logic [RECIP_HI_W-1:0] RECIP_M_HI = RECIP_M[RECIP_W-1:RECIP_LO_W];

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_REPLY   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_INIT  = 2'd1,
    ST_PARAM_ERR = 2'd2,
    ST_NOT_TRIG  = 2'd3
  } status_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ENABLED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS     = 1'd1;

  // Decoded command flags handed from the conversion pipe to the core
  typedef struct packed {
    cmd_t command;
    logic handler_present;
    logic trig_ok;
    logic reply_ok;
  } conv_ctl_t;

endpackage

[sv/rtcodt_if.sv]
// ----------------------------------------------------------------------------
// rtcodt_if
// Request and response channels of the one-shot delay timer.
// ----------------------------------------------------------------------------
interface rtcodt_req_if;
  import rtcodt_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [DELAY_W-1:0] delay_us;
  logic               handler_present;

  modport source (output valid, command, delay_us, handler_present, input ready);
  modport sink   (input valid, command, delay_us, handler_present, output ready);
endinterface

interface rtcodt_rsp_if;
  import rtcodt_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic                   expired;
  logic [COUNT_OUT_W-1:0] count_now;

  modport source (output valid, status, expired, count_now, input ready);
  modport sink   (input valid, status, expired, count_now, output ready);
endinterface

[sv/rtcodt_tick_conv.sv]
// ----------------------------------------------------------------------------
// rtcodt_tick_conv
// Three-stage pipe: input register, split reciprocal multiply, tick result.
// ----------------------------------------------------------------------------
module rtcodt_tick_conv #(
  parameter int COUNTER_BITS = rtcodt_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rtcodt_pkg::CMD_W-1:0]        command,
  input  logic [rtcodt_pkg::DELAY_W-1:0]      delay_us,
  input  logic                                handler_present,
  input  logic [rtcodt_pkg::MIN_TICKS_W-1:0]  min_ticks,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rtcodt_pkg::conv_ctl_t               out_ctl,
  output logic [COUNTER_BITS-1:0]             out_ticks
);
  import rtcodt_pkg::*;

  localparam int LO_PROD_W = DELAY_W + RECIP_LO_W;
  localparam int HI_PROD_W = DELAY_W + RECIP_HI_W;
  localparam int SUM_W     = HI_PROD_W + RECIP_LO_W + 1;
  localparam longint unsigned CNT_MASK     = (64'd1 << COUNTER_BITS) - 64'd1;
  localparam longint unsigned MAX_DELAY_US = US_PER_S * (CNT_MASK / TICK_HZ);

  // stage 1: input register
  logic               v1;
  cmd_t               cmd1;
  logic [DELAY_W-1:0] us1;
  logic               hp1;

  // stage 2: partial products
  logic                 v2;
  conv_ctl_t            ctl2;
  logic [LO_PROD_W-1:0] plo2;
  logic [HI_PROD_W-1:0] phi2;

  // stage 3: ticks
  logic                    v3;
  conv_ctl_t               ctl3;
  logic [COUNTER_BITS-1:0] ticks3;

  logic en1, en2, en3;
  logic [SUM_W-1:0]        prod_sum;
  logic [QUOT_W-1:0]       quot;
  logic [31:0]             quot32;
  logic [COUNTER_BITS-1:0] ticks_raw;
  logic [COUNTER_BITS-1:0] ticks_min;
  logic [63:0]             us_wide;

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign us_wide = 64'(us1);

  assign prod_sum  = SUM_W'({phi2, {RECIP_LO_W{1'b0}}}) + SUM_W'(plo2);
  assign quot      = prod_sum[RECIP_SHIFT +: QUOT_W];
  assign quot32    = 32'(quot);
  assign ticks_raw = quot32[COUNTER_BITS-1:0];
  assign ticks_min = COUNTER_BITS'(min_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1 <= cmd_t'(command);
      us1  <= delay_us;
      hp1  <= handler_present;
    end
    if (en2) begin
      ctl2.command         <= cmd1;
      ctl2.handler_present <= hp1;
      ctl2.trig_ok         <= (us_wide <= MAX_DELAY_US);
      ctl2.reply_ok        <= (us1 != '0) && (us_wide < MAX_DELAY_US);
      plo2 <= LO_PROD_W'(us1) * LO_PROD_W'(RECIP_M_LO);
      phi2 <= HI_PROD_W'(us1) * HI_PROD_W'(RECIP_M_HI);
    end
    if (en3) begin
      ctl3   <= ctl2;
      ticks3 <= (ticks_raw < ticks_min) ? ticks_min : ticks_raw;
    end
  end

  assign out_valid = v3;
  assign out_ctl   = ctl3;
  assign out_ticks = ticks3;

endmodule

[sv/rtcodt_core.sv]
// ----------------------------------------------------------------------------
// rtcodt_core
// Timer state, command decode and the result register.
// ----------------------------------------------------------------------------
module rtcodt_core #(
  parameter int COUNTER_BITS = rtcodt_pkg::COUNTER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rtcodt_pkg::conv_ctl_t               ctl,
  input  logic [COUNTER_BITS-1:0]             ticks,
  input  logic                                block_enabled,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [rtcodt_pkg::STATUS_W-1:0]     status,
  output logic                                expired,
  output logic [rtcodt_pkg::COUNT_OUT_W-1:0]  count_now
);
  import rtcodt_pkg::*;

  logic [COUNTER_BITS-1:0] tick_count, tick_count_next;
  logic [COUNTER_BITS-1:0] compare_value, compare_value_next;
  logic running, running_next;
  logic event_armed, event_armed_next;
  logic handler_set, handler_set_next;

  logic                    en;
  logic                    take;
  logic [COUNTER_BITS-1:0] prog_value;
  status_t                 st;
  logic                    exp;
  logic [31:0]             count32;

  assign en       = !rsp_valid || rsp_ready;
  assign take     = in_valid && en;
  assign in_ready = en;

  assign prog_value = tick_count + ticks;

  always_comb begin
    tick_count_next    = tick_count;
    compare_value_next = compare_value;
    running_next       = running;
    event_armed_next   = event_armed;
    handler_set_next   = handler_set;
    st                 = ST_OK;
    exp                = 1'b0;
    case (ctl.command)
      CMD_TICK: begin
        if (running) begin
          tick_count_next = tick_count + COUNTER_BITS'(1);
          exp = event_armed && (tick_count_next == compare_value);
        end
      end
      CMD_TRIGGER: begin
        if (!block_enabled) begin
          st = ST_NOT_INIT;
        end else if (!ctl.trig_ok || !ctl.handler_present) begin
          st = ST_PARAM_ERR;
        end else begin
          handler_set_next   = 1'b1;
          compare_value_next = prog_value;
          running_next       = 1'b1;
          event_armed_next   = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if (!handler_set) begin
          st = ST_NOT_TRIG;
        end else if (!block_enabled) begin
          st = ST_NOT_INIT;
        end else begin
          running_next     = 1'b0;
          handler_set_next = 1'b0;
        end
      end
      CMD_REPLY: begin
        if (handler_set && ctl.reply_ok) begin
          compare_value_next = prog_value;
          running_next       = running || block_enabled;
          event_armed_next   = 1'b1;
        end else begin
          event_armed_next = 1'b0;
          if (!handler_set) begin
            st = ST_NOT_TRIG;
          end else if (!block_enabled) begin
            st = ST_NOT_INIT;
          end else begin
            running_next     = 1'b0;
            handler_set_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign count32 = 32'(tick_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      compare_value <= '0;
      running       <= 1'b0;
      event_armed   <= 1'b0;
      handler_set   <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (en) rsp_valid <= in_valid;
      if (take) begin
        tick_count    <= tick_count_next;
        compare_value <= compare_value_next;
        running       <= running_next;
        event_armed   <= event_armed_next;
        handler_set   <= handler_set_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status    <= st;
      expired   <= exp;
      count_now <= count32[COUNT_OUT_W-1:0];
    end
  end

endmodule

[sv/rtc_one_shot_delay_timer_unit.sv]
// ----------------------------------------------------------------------------
// rtc_one_shot_delay_timer_unit
// One-shot delay timer on a tick counter, command in, one status word out.
// ----------------------------------------------------------------------------
// Usage:
//   request : one word per tick or command (tick, trigger, cancel, reply),
//             with delay_us and handler_present. Accepted on valid & ready.
//   result  : one word per request, in order: status, expired, count_now.
//   cfg     : write-only port, index 0 block_enabled, index 1 min_ticks.
//             Written while no request is in flight.
// Pipeline: four registers from request to result (input register loaded
//   on the accepting edge, split reciprocal multiply, tick sum and minimum,
//   state update into the result register).
// Throughput: 1 word per cycle unless stalled; each pipe stage and the result
//   register advance whenever the stage ahead is empty or being emptied.
// Reset: counter, compare value and flags cleared, pipe emptied,
//   block_enabled = 0, min_ticks = 3.
// Stall: a held result freezes the pipe back to request.ready; nothing
//   is dropped and the timer state only moves as results are produced.
// ----------------------------------------------------------------------------
module rtc_one_shot_delay_timer_unit #(
  parameter int COUNTER_BITS = rtcodt_pkg::COUNTER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rtcodt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtcodt_pkg::CFG_DATA_W-1:0]  cfg_data,
  rtcodt_req_if.sink                         request,
  rtcodt_rsp_if.source                       result
);
  import rtcodt_pkg::*;

  // Configuration registers
  logic                   block_enabled;
  logic [MIN_TICKS_W-1:0] min_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_enabled <= 1'b0;
      min_ticks     <= MIN_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_ENABLED: block_enabled <= cfg_data[0];
        REG_MIN_TICKS:     min_ticks     <= cfg_data[MIN_TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Microseconds to ticks; depends only on the word and min_ticks,
  // so it runs ahead of the state stage without hazards.
  logic                    conv_valid;
  logic                    conv_ready;
  conv_ctl_t               conv_ctl;
  logic [COUNTER_BITS-1:0] conv_ticks;

  rtcodt_tick_conv #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_conv (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (request.valid),
    .in_ready        (request.ready),
    .command         (request.command),
    .delay_us        (request.delay_us),
    .handler_present (request.handler_present),
    .min_ticks       (min_ticks),
    .out_valid       (conv_valid),
    .out_ready       (conv_ready),
    .out_ctl         (conv_ctl),
    .out_ticks       (conv_ticks)
  );

  // Counter, compare and flags; the result register lives here
  rtcodt_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (conv_valid),
    .in_ready      (conv_ready),
    .ctl           (conv_ctl),
    .ticks         (conv_ticks),
    .block_enabled (block_enabled),
    .rsp_valid     (result.valid),
    .rsp_ready     (result.ready),
    .status        (result.status),
    .expired       (result.expired),
    .count_now     (result.count_now)
  );

endmodule

[sv/rtcodt_checker.sv]
// ----------------------------------------------------------------------------
// rtcodt_checker
// Port-level checks of the one-shot delay timer, bound to the top level.
// ----------------------------------------------------------------------------
module rtcodt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [rtcodt_pkg::STATUS_W-1:0]     rsp_status,
  input logic                                rsp_expired,
  input logic [rtcodt_pkg::COUNT_OUT_W-1:0]  rsp_count
);
  import rtcodt_pkg::*;

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  // pipe is empty and open right after reset
  a_rst_ready: assert property (@(posedge clk) rst |=> req_ready)
    else $error("request not ready after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_expired) && $stable(rsp_count))
    else $error("stalled result changed");

  // between two successive results the counter moves by at most one tick
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready) ##1 (rsp_valid && rsp_ready) |->
      (rsp_count == $past(rsp_count)) || (rsp_count == $past(rsp_count) + 1'b1)
      || (rsp_count == '0))
    else $error("counter jumped between results");

endmodule

bind rtc_one_shot_delay_timer_unit rtcodt_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (request.ready),
  .rsp_valid   (result.valid),
  .rsp_ready   (result.ready),
  .rsp_status  (result.status),
  .rsp_expired (result.expired),
  .rsp_count   (result.count_now)
);
